[rtl/core/ssq_pkg.sv]
// ----------------------------------------------------------------------------
// ssq_pkg
// Shared types and constants for the sorted set successor query block.
// ----------------------------------------------------------------------------
package ssq_pkg;

    localparam int CAP = 64;
    localparam int VW  = 16;
    localparam int AW  = $clog2(CAP);
    localparam int CW  = $clog2(CAP + 1);

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_QUERY  = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_NONE = 2'd2
    } t_status;

    typedef struct packed {
        logic          we;
        logic [AW-1:0] waddr;
        logic [VW-1:0] wdata;
        logic [AW-1:0] raddr;
    } t_ram_req;

    typedef struct packed {
        logic          valid;
        logic [VW-1:0] value;
        t_status       status;
    } t_result;

endpackage

[rtl/core/ssq_ram.sv]
// ----------------------------------------------------------------------------
// ssq_ram
// Value store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ssq_ram import ssq_pkg::*; (
    input  logic          i_clk,
    input  t_ram_req      i_req,
    output logic [VW-1:0] o_rd_data
);

    logic [VW-1:0] r_mem [CAP];
    logic [VW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rd_data <= r_mem[i_req.raddr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/core/ssq_seq.sv]
// ----------------------------------------------------------------------------
// ssq_seq
// Sequencer: scans the store for queries, shifts entries up for inserts,
// and keeps the entry count.
// ----------------------------------------------------------------------------
module ssq_seq import ssq_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic [1:0]    i_action,
    input  logic [VW-1:0] i_value,
    input  logic          i_out_free,
    output t_result       o_result,
    output t_ram_req      o_ram,
    input  logic [VW-1:0] i_rd_data
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_QRD  = 6'b000010,
        S_QCHK = 6'b000100,
        S_IRD  = 6'b001000,
        S_ICHK = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx, n_idx;
    logic [VW-1:0] r_value, n_value;
    logic [VW-1:0] r_res_value, n_res_value;
    t_status       r_res_status, n_res_status;
    logic [CW-1:0] idx_dec;

    assign idx_dec = r_idx - CW'(1);

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_value      = r_value;
        n_res_value  = r_res_value;
        n_res_status = r_res_status;
        o_ram.we     = 1'b0;
        o_ram.waddr  = r_idx[AW-1:0];
        o_ram.wdata  = r_value;
        o_ram.raddr  = r_idx[AW-1:0];
        o_result.valid  = 1'b0;
        o_result.value  = r_res_value;
        o_result.status = r_res_status;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_value      = i_value;
                    n_res_value  = '0;
                    n_res_status = ST_OK;
                    unique case (i_action)
                        ACT_CLEAR: begin
                            n_count = '0;
                            n_state = S_DONE;
                        end
                        ACT_INSERT: begin
                            if (r_count >= CW'(CAP)) begin
                                n_res_status = ST_FULL;
                                n_state      = S_DONE;
                            end else begin
                                n_idx   = r_count;
                                n_state = S_IRD;
                            end
                        end
                        ACT_QUERY: begin
                            n_idx   = '0;
                            n_state = S_QRD;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_QRD: begin
                if (r_idx == r_count) begin
                    n_res_status = ST_NONE;
                    n_state      = S_DONE;
                end else begin
                    n_state = S_QCHK;
                end
            end
            S_QCHK: begin
                if (i_rd_data > r_value) begin
                    n_res_value = i_rd_data;
                    n_state     = S_DONE;
                end else begin
                    n_idx   = r_idx + CW'(1);
                    n_state = S_QRD;
                end
            end
            S_IRD: begin
                if (r_idx == '0) begin
                    o_ram.we = 1'b1;
                    n_count  = r_count + CW'(1);
                    n_state  = S_DONE;
                end else begin
                    o_ram.raddr = idx_dec[AW-1:0];
                    n_state     = S_ICHK;
                end
            end
            S_ICHK: begin
                o_ram.we = 1'b1;
                if (i_rd_data > r_value) begin
                    o_ram.wdata = i_rd_data;
                    n_idx       = idx_dec;
                    n_state     = S_IRD;
                end else begin
                    n_count = r_count + CW'(1);
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_result.valid = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_idx        <= n_idx;
        r_value      <= n_value;
        r_res_value  <= n_res_value;
        r_res_status <= n_res_status;
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

[rtl/core/sorted_set_successor_query.sv]
// ----------------------------------------------------------------------------
// sorted_set_successor_query
// Sorted multiset with clear, insert and upper-bound query beats.
// Clear, an insert into a full store and the unused code go straight to the done state.
// Query: reads and compares entries from the lowest up until one is greater, or all are read.
// Insert: moves each stored entry greater than the value up one place, top down, then writes it.
// One beat is in the sequencer at a time; the next is taken once the result is handed to the output register.
// Reset: synchronous, active low; clears the entry count, store is not swept.
// ----------------------------------------------------------------------------
module sorted_set_successor_query import ssq_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] item_value
    input  logic [1:0]  s_axis_tuser,   // [1:0] action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] successor_value
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    t_result       result;
    t_ram_req      ram_req;
    logic [VW-1:0] rd_data;
    logic          out_free;
    logic          r_out_valid;
    logic [VW-1:0] r_out_value;
    t_status       r_out_status;

    assign out_free = !r_out_valid || m_axis_tready;

    ssq_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_action   (s_axis_tuser),
        .i_value    (VW'(s_axis_tdata)),
        .i_out_free (out_free),
        .o_result   (result),
        .o_ram      (ram_req),
        .i_rd_data  (rd_data)
    );

    ssq_ram u_ram (
        .i_clk     (i_clk),
        .i_req     (ram_req),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (result.valid) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (result.valid) begin
            r_out_value  <= result.value;
            r_out_status <= result.status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = 16'(r_out_value);
    assign m_axis_tuser  = r_out_status;

endmodule

[sim/tb_sorted_set_successor_query.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_set_successor_query
// Self-checking bench for the sorted multiset block: a scoreboard keeps its
// own sorted store and predicts every result beat; directed beats cover
// extremes, duplicates, an empty store and the unused action code, then
// random clear/insert/query phases, which can fill the store, run with
// random gaps on both sides and long receiver hold-offs.
// ----------------------------------------------------------------------------
module tb_sorted_set_successor_query;
    import ssq_pkg::*;

    localparam logic [1:0] ACT_UNUSED  = 2'd3;
    localparam int         RAND_ITEMS  = 1200;
    localparam int         HOLD_CYCLES = 600;
    localparam int         DRAIN       = 300;
    localparam int         LIMIT       = 1000000;

    typedef struct {
        logic [15:0] value;
        logic [1:0]  status;
    } succ_result_t;

    class successor_scoreboard;
        logic [15:0]  store [CAP];
        int unsigned  count;
        succ_result_t pending_q [$];
        int unsigned  errors;

        function new();
            count  = 0;
            errors = 0;
        endfunction

        function int unsigned upper_pos(logic [15:0] v);
            for (int unsigned i = 0; i < count; i++) begin
                if (store[i] > v) return i;
            end
            return count;
        endfunction

        function void note_item(logic [1:0] act, logic [15:0] v);
            succ_result_t r;
            int unsigned  pos;
            r.value  = '0;
            r.status = ST_OK;
            case (act)
                ACT_CLEAR: begin
                    count = 0;
                end
                ACT_INSERT: begin
                    if (count >= CAP) begin
                        r.status = ST_FULL;
                    end else begin
                        pos = upper_pos(v);
                        for (int unsigned j = count; j > pos; j--) store[j] = store[j-1];
                        store[pos] = v;
                        count++;
                    end
                end
                ACT_QUERY: begin
                    pos = upper_pos(v);
                    if (pos < count) r.value = store[pos];
                    else r.status = ST_NONE;
                end
                default: ;
            endcase
            pending_q.push_back(r);
        endfunction

        function void check_result(logic [15:0] value, logic [1:0] status);
            succ_result_t r;
            if (pending_q.size() == 0) begin
                $error("unexpected result beat: successor_value %0d, status %0d",
                       value, status);
                errors++;
                return;
            end
            r = pending_q.pop_front();
            if (value !== r.value) begin
                $error("successor_value: expected %0d, actual %0d", r.value, value);
                errors++;
            end
            if (status !== r.status) begin
                $error("status: expected %0d, actual %0d", r.status, status);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [15:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tready = 1'b0;
    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [15:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    logic        calm = 1'b0;
    int unsigned items_sent   = 0;
    int unsigned results_seen = 0;
    int unsigned cycles       = 0;

    successor_scoreboard sb = new();

    sorted_set_successor_query uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_tdata),        // [15:0] item_value
        .s_axis_tuser  (s_tuser),        // [1:0] action
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_axis_tdata),   // [15:0] successor_value
        .m_axis_tuser  (m_axis_tuser)    // [1:0] status
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        forever begin
            if (calm) repeat ($urandom_range(50, 200)) @(posedge i_clk);
            else repeat ($urandom_range(150, 600)) @(posedge i_clk);
            calm <= ~calm;
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] pick_value();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 25) return 16'($urandom_range(0, 15));
        if (r < 35) begin
            case ($urandom_range(0, 3))
                0: return 16'h0000;
                1: return 16'h0001;
                2: return 16'hFFFE;
                default: return 16'hFFFF;
            endcase
        end
        if (r < 60 && sb.count > 0)
            return sb.store[$urandom_range(0, sb.count - 1)] + 16'($urandom_range(0, 2)) - 16'd1;
        return 16'($urandom_range(0, 65535));
    endfunction

    task automatic send_beat(logic [1:0] act, logic [15:0] v);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tuser  <= act;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_item(act, v);
        if (act != ACT_UNUSED) items_sent++;
    endtask

    task automatic run_phase(int unsigned n_ins);
        int unsigned done_ins;
        int unsigned r;
        done_ins = 0;
        if ($urandom_range(0, 99) < 85) send_beat(ACT_CLEAR, pick_value());
        while (done_ins < n_ins) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                send_beat(ACT_INSERT, pick_value());
                done_ins++;
            end else if (r < 95) begin
                send_beat(ACT_QUERY, pick_value());
            end else begin
                send_beat(ACT_UNUSED, pick_value());
            end
        end
        repeat ($urandom_range(3, 15)) send_beat(ACT_QUERY, pick_value());
    endtask

    initial begin : source
        @(posedge i_clk iff i_rst_n);
        send_beat(ACT_CLEAR,  16'h0000);
        send_beat(ACT_QUERY,  16'h0000);
        send_beat(ACT_QUERY,  16'hFFFF);
        send_beat(ACT_INSERT, 16'h0000);
        send_beat(ACT_INSERT, 16'hFFFF);
        send_beat(ACT_INSERT, 16'd100);
        send_beat(ACT_INSERT, 16'd100);
        send_beat(ACT_QUERY,  16'h0000);
        send_beat(ACT_QUERY,  16'd99);
        send_beat(ACT_QUERY,  16'd100);
        send_beat(ACT_QUERY,  16'hFFFE);
        send_beat(ACT_QUERY,  16'hFFFF);
        send_beat(ACT_UNUSED, 16'hFFFF);
        send_beat(ACT_UNUSED, 16'h5A5A);
        send_beat(ACT_QUERY,  16'd50);
        send_beat(ACT_INSERT, 16'h8000);
        send_beat(ACT_QUERY,  16'h7FFF);
        send_beat(ACT_CLEAR,  16'hFFFF);
        send_beat(ACT_QUERY,  16'h0000);
        send_beat(ACT_INSERT, 16'h5555);
        send_beat(ACT_QUERY,  16'h5555);
        send_beat(ACT_QUERY,  16'h5554);
        items_sent = 0;
        run_phase(70);
        while (items_sent < RAND_ITEMS) begin
            if ($urandom_range(0, 99) < 30) run_phase($urandom_range(60, 80));
            else run_phase($urandom_range(1, 40));
        end
        s_tvalid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin : sink
        int unsigned stall_left;
        int unsigned gap;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_tready) begin
                sb.check_result(m_axis_tdata, m_axis_tuser);
                results_seen++;
                if (results_seen == 300 || results_seen == 900) stall_left = HOLD_CYCLES;
            end
            if (!i_rst_n) begin
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                gap = ($urandom_range(0, 99) < 25) ? pick_gap() : 0;
                if (gap > 0) begin
                    m_tready   <= 1'b0;
                    stall_left = gap - 1;
                end else begin
                    m_tready <= 1'b1;
                end
            end
        end
    end

endmodule
